// ----- hdl/tfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_pkg: shared types and constants for the texel format converter
// Source format codes and the per-channel word handed to the widening stage.
// ----------------------------------------------------------------------------
package tfa_pkg;

  localparam logic [3:0] MODE_A8       = 4'd0;
  localparam logic [3:0] MODE_L8       = 4'd1;
  localparam logic [3:0] MODE_LA88     = 4'd2;
  localparam logic [3:0] MODE_RGB888   = 4'd3;
  localparam logic [3:0] MODE_RGBA8888 = 4'd4;
  localparam logic [3:0] MODE_BGRA8888 = 4'd5;
  localparam logic [3:0] MODE_RGB565   = 4'd6;
  localparam logic [3:0] MODE_RGBA4444 = 4'd7;
  localparam logic [3:0] MODE_RGBA5551 = 4'd8;

  localparam logic [7:0] CHAN_FULL = 8'd255;
  localparam logic [7:0] CHAN_ZERO = 8'd0;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_W4   = 2'd1,
    KIND_W5   = 2'd2,
    KIND_W6   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
  } chan_t;

endpackage

// ----- hdl/texel_format_to_argb8888.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_argb8888: texel format to 8-bit ARGB converter
// Four-stage pipeline: capture, field decode, widen estimate, correct.
//
//   channel  ports                               handshake
//   in       in_byte0..in_byte3                  in_valid / in_ready
//   out      out_alpha_out, out_red_out,         out_valid / out_ready
//            out_green_out, out_blue_out
//   cfg      cfg_wdata (pixel_mode)              cfg_we, no wait
//
// One word per cycle unless out_ready stalls; out_valid is the correct stage's valid.
// Mode is sampled with each word at accept.
// Reset clears stage valids and sets the mode to rgba8888.
// A stall on out_ready freezes all stages together; in_ready drops with it.
// ----------------------------------------------------------------------------
module texel_format_to_argb8888
  import tfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte0,
  input  logic [7:0] in_byte1,
  input  logic [7:0] in_byte2,
  input  logic [7:0] in_byte3,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_alpha_out,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic        adv;
  logic [3:0]  mode_r;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic [3:0]  mode1_r;
  logic [7:0]  b0_r, b1_r, b2_r, b3_r;
  logic [15:0] packed_w;
  chan_t       a_nxt, r_nxt, g_nxt, b_nxt;
  chan_t       a_r, r_r, g_r, b_r;

  assign adv      = !v4_r || out_ready;
  assign in_ready = adv;
  assign packed_w = {b1_r, b0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGBA8888;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode_r;
      b0_r    <= in_byte0;
      b1_r    <= in_byte1;
      b2_r    <= in_byte2;
      b3_r    <= in_byte3;
      a_r     <= a_nxt;
      r_r     <= r_nxt;
      g_r     <= g_nxt;
      b_r     <= b_nxt;
    end
  end

  always_comb begin
    a_nxt = '{kind: KIND_PASS, val: CHAN_FULL};
    r_nxt = '{kind: KIND_PASS, val: CHAN_ZERO};
    g_nxt = '{kind: KIND_PASS, val: CHAN_ZERO};
    b_nxt = '{kind: KIND_PASS, val: CHAN_ZERO};
    unique case (mode1_r)
      MODE_A8: begin
        a_nxt.val = b0_r;
        r_nxt.val = CHAN_FULL;
        g_nxt.val = CHAN_FULL;
        b_nxt.val = CHAN_FULL;
      end
      MODE_L8: begin
        r_nxt.val = b0_r;
        g_nxt.val = b0_r;
        b_nxt.val = b0_r;
      end
      MODE_LA88: begin
        a_nxt.val = b1_r;
        r_nxt.val = b0_r;
        g_nxt.val = b0_r;
        b_nxt.val = b0_r;
      end
      MODE_RGB888: begin
        r_nxt.val = b0_r;
        g_nxt.val = b1_r;
        b_nxt.val = b2_r;
      end
      MODE_RGBA8888: begin
        a_nxt.val = b3_r;
        r_nxt.val = b0_r;
        g_nxt.val = b1_r;
        b_nxt.val = b2_r;
      end
      MODE_BGRA8888: begin
        a_nxt.val = b3_r;
        r_nxt.val = b2_r;
        g_nxt.val = b1_r;
        b_nxt.val = b0_r;
      end
      MODE_RGB565: begin
        r_nxt = '{kind: KIND_W5, val: 8'(packed_w[15:11])};
        g_nxt = '{kind: KIND_W6, val: 8'(packed_w[10:5])};
        b_nxt = '{kind: KIND_W5, val: 8'(packed_w[4:0])};
      end
      MODE_RGBA4444: begin
        r_nxt = '{kind: KIND_W4, val: 8'(packed_w[15:12])};
        g_nxt = '{kind: KIND_W4, val: 8'(packed_w[11:8])};
        b_nxt = '{kind: KIND_W4, val: 8'(packed_w[7:4])};
        a_nxt = '{kind: KIND_W4, val: 8'(packed_w[3:0])};
      end
      MODE_RGBA5551: begin
        r_nxt = '{kind: KIND_W5, val: 8'(packed_w[15:11])};
        g_nxt = '{kind: KIND_W5, val: 8'(packed_w[10:6])};
        b_nxt = '{kind: KIND_W5, val: 8'(packed_w[5:1])};
        a_nxt.val = packed_w[0] ? CHAN_FULL : CHAN_ZERO;
      end
      default: begin
        a_nxt.val = CHAN_ZERO;
      end
    endcase
  end

  tfa_widen u_wid_a (.clk(clk), .en(adv), .chan_i(a_r), .res_o(out_alpha_out));
  tfa_widen u_wid_r (.clk(clk), .en(adv), .chan_i(r_r), .res_o(out_red_out));
  tfa_widen u_wid_g (.clk(clk), .en(adv), .chan_i(g_r), .res_o(out_green_out));
  tfa_widen u_wid_b (.clk(clk), .en(adv), .chan_i(b_r), .res_o(out_blue_out));

  assign out_valid = v4_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r}))
    else $error("pipeline valids moved during stall");

  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted word missing from first stage");

  a_s2_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && adv |=> v3_r)
    else $error("decode stage word lost");

  a_s3_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && adv |=> v4_r)
    else $error("widen stage word lost");

endmodule

// ----- hdl/tfa_widen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfa_widen: two-stage channel widener
// Estimate by bit replication, then correct against round(v*255/max).
// ----------------------------------------------------------------------------
module tfa_widen
  import tfa_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  chan_t      chan_i,
  output logic [7:0] res_o
);

  logic [13:0] x_r, x_nxt;
  logic [7:0]  e_r, e_nxt;
  kind_t       kind_r;
  logic [7:0]  res_r, res_nxt;
  logic [5:0]  m;
  logic [13:0] p;

  always_comb begin
    e_nxt = chan_i.val;
    x_nxt = '0;
    unique case (chan_i.kind)
      KIND_PASS: begin
        e_nxt = chan_i.val;
        x_nxt = '0;
      end
      KIND_W4: begin
        e_nxt = {chan_i.val[3:0], chan_i.val[3:0]};
        x_nxt = 14'(chan_i.val[3:0]) * 14'd255 + 14'd7;
      end
      KIND_W5: begin
        e_nxt = {chan_i.val[4:0], chan_i.val[4:2]};
        x_nxt = 14'(chan_i.val[4:0]) * 14'd255 + 14'd15;
      end
      KIND_W6: begin
        e_nxt = {chan_i.val[5:0], chan_i.val[5:4]};
        x_nxt = 14'(chan_i.val[5:0]) * 14'd255 + 14'd31;
      end
      default: begin
        e_nxt = chan_i.val;
        x_nxt = '0;
      end
    endcase
  end

  always_comb begin
    unique case (kind_r)
      KIND_W4: m = 6'd15;
      KIND_W5: m = 6'd31;
      KIND_W6: m = 6'd63;
      default: m = 6'd0;
    endcase
  end

  assign p = 14'(e_r) * 14'(m);

  always_comb begin
    res_nxt = e_r;
    if (kind_r != KIND_PASS) begin
      if (x_r < p) begin
        res_nxt = e_r - 8'd1;
      end else if ((x_r - p) >= 14'(m)) begin
        res_nxt = e_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      e_r    <= e_nxt;
      kind_r <= chan_i.kind;
      res_r  <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for texel_format_to_argb8888
// Each accepted texel is converted in the bench for the current source format
// and queued. Each output word is checked field by field against the oldest
// queued texel. The run covers the reset format, directed extremes in every
// format, the undefined format codes and random bursts under three idle
// mixes. One long output hold lets the pipeline fill and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import tfa_pkg::*;

  localparam logic [3:0] MODE_UNDEF_FIRST = 4'd9;
  localparam logic [3:0] MODE_UNDEF_LAST  = 4'd15;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte0;
  logic [7:0] in_byte1;
  logic [7:0] in_byte2;
  logic [7:0] in_byte3;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_alpha_out;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  argb_t      expected_texels[$];
  logic [3:0] src_format;
  int         error_count;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_left;

  texel_format_to_argb8888 uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte0     (in_byte0),
    .in_byte1     (in_byte1),
    .in_byte2     (in_byte2),
    .in_byte3     (in_byte3),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_alpha_out(out_alpha_out),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] expand_field(input int unsigned v, input int unsigned m);
    int unsigned wide;
    wide = (v * 255 + m / 2) / m;
    return wide[7:0];
  endfunction

  function automatic argb_t convert_texel(input logic [3:0] fmt, input logic [7:0] b0,
                                          input logic [7:0] b1, input logic [7:0] b2,
                                          input logic [7:0] b3);
    argb_t       t;
    logic [15:0] pk;
    pk = {b1, b0};
    t = '{alpha: CHAN_FULL, red: CHAN_ZERO, green: CHAN_ZERO, blue: CHAN_ZERO};
    unique case (fmt)
      MODE_A8: begin
        t = '{alpha: b0, red: CHAN_FULL, green: CHAN_FULL, blue: CHAN_FULL};
      end
      MODE_L8: begin
        t.red = b0; t.green = b0; t.blue = b0;
      end
      MODE_LA88: begin
        t = '{alpha: b1, red: b0, green: b0, blue: b0};
      end
      MODE_RGB888: begin
        t.red = b0; t.green = b1; t.blue = b2;
      end
      MODE_RGBA8888: begin
        t = '{alpha: b3, red: b0, green: b1, blue: b2};
      end
      MODE_BGRA8888: begin
        t = '{alpha: b3, red: b2, green: b1, blue: b0};
      end
      MODE_RGB565: begin
        t.red   = expand_field(32'(pk[15:11]), 31);
        t.green = expand_field(32'(pk[10:5]), 63);
        t.blue  = expand_field(32'(pk[4:0]), 31);
      end
      MODE_RGBA4444: begin
        t.red   = expand_field(32'(pk[15:12]), 15);
        t.green = expand_field(32'(pk[11:8]), 15);
        t.blue  = expand_field(32'(pk[7:4]), 15);
        t.alpha = expand_field(32'(pk[3:0]), 15);
      end
      MODE_RGBA5551: begin
        t.red   = expand_field(32'(pk[15:11]), 31);
        t.green = expand_field(32'(pk[10:6]), 31);
        t.blue  = expand_field(32'(pk[5:1]), 31);
        t.alpha = pk[0] ? CHAN_FULL : CHAN_ZERO;
      end
      default: begin
        t = '0;
      end
    endcase
    return t;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom);
  endfunction

  task automatic send_texel(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte0 <= b0;
    in_byte1 <= b1;
    in_byte2 <= b2;
    in_byte3 <= b3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_texels.push_back(convert_texel(src_format, b0, b1, b2, b3));
  endtask

  task automatic set_format(input logic [3:0] fmt);
    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    src_format = fmt;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_format();
    send_texel(8'h11, 8'h22, 8'h33, 8'h44);
    send_texel(8'hff, 8'h00, 8'hff, 8'h00);
  endtask

  task automatic test_directed_formats();
    set_format(MODE_A8);
    send_texel(8'h5a, 8'hff, 8'hff, 8'hff);
    set_format(MODE_L8);
    send_texel(8'ha5, 8'h00, 8'hff, 8'h00);
    set_format(MODE_LA88);
    send_texel(8'h3c, 8'hc3, 8'h00, 8'hff);
    set_format(MODE_RGB888);
    send_texel(8'h01, 8'h80, 8'hfe, 8'h00);
    set_format(MODE_RGBA8888);
    send_texel(8'hff, 8'hff, 8'hff, 8'hff);
    send_texel(8'h00, 8'h00, 8'h00, 8'h00);
    set_format(MODE_BGRA8888);
    send_texel(8'h12, 8'h34, 8'h56, 8'h78);
    set_format(MODE_RGB565);
    send_texel(8'h00, 8'h00, 8'hff, 8'hff);
    send_texel(8'hff, 8'hff, 8'h00, 8'h00);
    send_texel(8'h10, 8'h84, 8'h00, 8'h00);
    set_format(MODE_RGBA4444);
    send_texel(8'h00, 8'h00, 8'hff, 8'hff);
    send_texel(8'hff, 8'hff, 8'h00, 8'h00);
    send_texel(8'h78, 8'h87, 8'h00, 8'h00);
    set_format(MODE_RGBA5551);
    send_texel(8'hfe, 8'hff, 8'h00, 8'h00);
    send_texel(8'h01, 8'h00, 8'hff, 8'hff);
    send_texel(8'h42, 8'h84, 8'h00, 8'h00);
    set_format(MODE_UNDEF_FIRST);
    send_texel(8'hff, 8'hff, 8'hff, 8'hff);
    set_format(MODE_UNDEF_LAST);
    send_texel(8'h7f, 8'h80, 8'h01, 8'hfe);
  endtask

  task automatic test_random_stream(input int n_texels);
    int         sent;
    logic [3:0] fmt;
    sent = 0;
    while (sent < n_texels) begin
      if ($urandom_range(9) == 0) begin
        fmt = 4'($urandom_range(MODE_UNDEF_LAST, MODE_UNDEF_FIRST));
      end else begin
        fmt = 4'($urandom_range(MODE_RGBA5551, MODE_A8));
      end
      set_format(fmt);
      repeat ($urandom_range(30, 8)) begin
        send_texel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        sent++;
      end
    end
  endtask

  task automatic test_output_hold();
    set_format(MODE_RGB565);
    hold_left = HOLD_CYCLES;
    repeat (30) send_texel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    argb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_texels.size() == 0) begin
        $error("unexpected output word: a=%0d r=%0d g=%0d b=%0d",
               out_alpha_out, out_red_out, out_green_out, out_blue_out);
        error_count++;
      end else begin
        want = expected_texels.pop_front();
        check_field("alpha_out", want.alpha, out_alpha_out);
        check_field("red_out", want.red, out_red_out);
        check_field("green_out", want.green, out_green_out);
        check_field("blue_out", want.blue, out_blue_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** texel_format_to_argb8888: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte0      = 8'h00;
    in_byte1      = 8'h00;
    in_byte2      = 8'h00;
    in_byte3      = 8'h00;
    cfg_we        = 1'b0;
    cfg_wdata     = 4'd0;
    src_format    = MODE_RGBA8888;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_format();
    test_directed_formats();
    send_idle_pct = 9;
    recv_idle_pct = 48;
    test_random_stream(130);
    send_idle_pct = 48;
    recv_idle_pct = 9;
    test_random_stream(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(130);
    test_output_hold();

    in_valid <= 1'b0;
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 3) @(posedge clk);
    if (expected_texels.size() != 0) begin
      $error("%0d expected words never arrived", expected_texels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** texel_format_to_argb8888: PASSED **");
    end else begin
      $display("** texel_format_to_argb8888: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tfa_pkg.sv
hdl/tfa_widen.sv
hdl/texel_format_to_argb8888.sv
tb/tb_top.sv
